@@ rtl/verlet_body_integrator_defines.svh @@
// assertion macros shared by the integrator rtl
`ifndef VERLET_BODY_INTEGRATOR_DEFINES_SVH
`define VERLET_BODY_INTEGRATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VBI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define VBI_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define VBI_ASSERT(lbl, clk, rstn, prop)
`define VBI_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ rtl/vbi_pkg.sv @@
// types and codes shared by the integrator rtl
`timescale 1ns / 1ps

package vbi_pkg;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_FORCE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_RATE = 2'd1;

    localparam logic [15:0] TIME_STEP_RST = 16'd1092;
    localparam logic [30:0] HALF_RATE_RST = 31'd1966080;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FORCE   = 3'd1,
        ST_BODY    = 3'd2,
        ST_FULL    = 3'd3,
        ST_BAD_IDX = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } recip_stat_t;

endpackage

@@ rtl/vbi_if.sv @@
// request, result and configuration channels of the integrator
`timescale 1ns / 1ps

interface vbi_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [4:0]        body_index;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]       mass;

    modport source (output valid, mode, body_index, ax, ay, az, vx, vy, vz, mass,
                    input ready);
    modport sink (input valid, mode, body_index, ax, ay, az, vx, vy, vz, mass,
                  output ready);
endinterface

interface vbi_rsp_if;
    logic               valid;
    logic               ready;
    vbi_pkg::status_t   status;
    logic [4:0]         body_id;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] velx;
    logic signed [31:0] vely;
    logic signed [31:0] velz;
    logic               last;

    modport source (output valid, status, body_id, px, py, pz, velx, vely, velz, last,
                    input ready);
    modport sink (input valid, status, body_id, px, py, pz, velx, vely, velz, last,
                  output ready);
endinterface

interface vbi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vbi_pkg::CFG_IDX_W-1:0]   index;
    logic [31:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/vbi_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module vbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/vbi_recip.sv @@
// radix-2 restoring divider forming 2^32 / mass, saturated
`timescale 1ns / 1ps

module vbi_recip (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          mass,
    output vbi_pkg::recip_stat_t stat,
    output logic [31:0]          quotient
);
    import vbi_pkg::*;

    localparam logic [5:0] STEPS = 6'd33;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;
    logic [31:0] mass_reg, mass_next;
    logic [32:0] rem_sh;
    logic        ge;

    // dividend is a single one at bit 32, fed in on the first step
    assign rem_sh = {rem_reg, (cnt_reg == STEPS)};
    assign ge     = (rem_sh >= {1'b0, mass_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mass_next = mass_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            rem_next  = '0;
            quo_next  = '0;
            mass_next = mass;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(rem_sh - {1'b0, mass_reg}) : rem_sh[31:0];
            quo_next = {quo_reg[31:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        mass_reg <= mass_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = (mass_reg == 32'd0) ? 32'd0 :
                       (quo_reg[32] ? 32'hFFFF_FFFF : quo_reg[31:0]);

endmodule

@@ rtl/verlet_body_integrator.sv @@
// position verlet integrator over a table of point bodies
`timescale 1ns / 1ps
`include "verlet_body_integrator_defines.svh"

// One request at a time; cmd.ready is low while a request is worked and
// while a result waits on rsp. An add waits on the 33-step reciprocal
// divider; a force set writes the three axes in turn; a tick works each
// body axis by axis through one shared 33x33 multiplier and the single
// read port of each body ram, and holds a body while the previous body
// result waits on rsp. Results of a tick come one per body in index order,
// last marking the highest body. Configuration writes are taken at once.
module verlet_body_integrator #(
    parameter int MAX_BODIES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    vbi_cmd_if.sink   cmd,
    vbi_rsp_if.source rsp,
    vbi_cfg_if.sink   cfg
);
    import vbi_pkg::*;

    localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam int VD = MAX_BODIES * 4;
    localparam int AW = IW + 2;

    typedef enum logic [16:0] {
        S_IDLE = 17'b00000000000000001,
        S_AWR  = 17'b00000000000000010,
        S_ADIV = 17'b00000000000000100,
        S_FWR  = 17'b00000000000001000,
        S_RD   = 17'b00000000000010000,
        S_MF   = 17'b00000000000100000,
        S_A1   = 17'b00000000001000000,
        S_A2   = 17'b00000000010000000,
        S_A3   = 17'b00000000100000000,
        S_A4   = 17'b00000001000000000,
        S_A5   = 17'b00000010000000000,
        S_A6   = 17'b00000100000000000,
        S_NP   = 17'b00001000000000000,
        S_DF   = 17'b00010000000000000,
        S_V1   = 17'b00100000000000000,
        S_V2   = 17'b01000000000000000,
        S_V3   = 17'b10000000000000000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -52'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // control
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [1:0]      axis_reg, axis_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     ts_reg, ts_next;
    logic [30:0]     hr_reg, hr_next;

    // payload
    logic signed [31:0] a_reg [3];
    logic [31:0]        mass_reg;
    status_t            status_reg, status_next;
    logic [4:0]         id_reg, id_next;
    logic               last_reg, last_next;
    logic signed [31:0] po_reg [3];
    logic signed [31:0] vo_reg [3];
    logic signed [65:0] prod_reg;
    logic signed [32:0] hi_reg, hi_next;
    logic [30:0]        tmp_reg, tmp_next;
    logic signed [49:0] sum_reg, sum_next;
    logic signed [31:0] np_reg, np_next;
    logic signed [33:0] diff_reg, diff_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [49:0] prod_plus;
    logic signed [51:0] np_wide;
    logic signed [31:0] vel_sat;

    logic               cmd_fire, rsp_fire, full;
    logic               idx_ok;

    // body storage
    logic               pos_we, prev_we, frc_we;
    logic [AW-1:0]      waddr, raddr;
    logic [31:0]        pos_wd, prev_wd, frc_wd;
    logic signed [31:0] pos_q, prev_q, frc_q;
    logic               im_we;
    logic [31:0]        im_q, recip_q;
    recip_stat_t        recip_stat;
    logic               recip_start;

    assign cmd_fire = cmd.valid & cmd.ready;
    assign rsp_fire = rsp.valid & rsp.ready;
    assign full     = (count_reg == CW'(MAX_BODIES));
    assign idx_ok   = (32'(cmd.body_index) < 32'(count_reg));
    assign raddr    = {idx_reg, axis_reg};

    vbi_ram #(.WIDTH(32), .DEPTH(VD)) u_pos (
        .clk(clk), .we(pos_we), .waddr(waddr), .wdata(pos_wd),
        .raddr(raddr), .rdata(pos_q)
    );
    vbi_ram #(.WIDTH(32), .DEPTH(VD)) u_prev (
        .clk(clk), .we(prev_we), .waddr(waddr), .wdata(prev_wd),
        .raddr(raddr), .rdata(prev_q)
    );
    vbi_ram #(.WIDTH(32), .DEPTH(VD)) u_frc (
        .clk(clk), .we(frc_we), .waddr(waddr), .wdata(frc_wd),
        .raddr(raddr), .rdata(frc_q)
    );
    vbi_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_imass (
        .clk(clk), .we(im_we), .waddr(count_reg[IW-1:0]), .wdata(recip_q),
        .raddr(idx_reg), .rdata(im_q)
    );

    vbi_recip u_recip (
        .clk(clk), .rst_n(rst_n), .start(recip_start), .mass(mass_reg),
        .stat(recip_stat), .quotient(recip_q)
    );

    assign recip_start = (state_reg == S_AWR) && (axis_reg == 2'd2);
    assign im_we       = (state_reg == S_ADIV) && recip_stat.done;

    // ram writes
    always_comb
    begin
        pos_we  = 1'b0;
        prev_we = 1'b0;
        frc_we  = 1'b0;
        waddr   = {idx_reg, axis_reg};
        pos_wd  = a_reg[axis_reg];
        prev_wd = a_reg[axis_reg];
        frc_wd  = '0;
        case (state_reg)
            S_AWR:
            begin
                waddr   = {count_reg[IW-1:0], axis_reg};
                pos_we  = 1'b1;
                prev_we = 1'b1;
                frc_we  = 1'b1;
            end
            S_FWR:
            begin
                frc_we = 1'b1;
                frc_wd = a_reg[axis_reg];
            end
            S_V3:
            begin
                pos_we  = 1'b1;
                prev_we = 1'b1;
                frc_we  = 1'b1;
                pos_wd  = np_reg;
                prev_wd = pos_q;
            end
            default:
            begin
            end
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MF:
            begin
                mul_a = {frc_q[31], frc_q};
                mul_b = {1'b0, im_q};
            end
            S_A1:
            begin
                mul_a = $signed({17'd0, prod_reg[31:16]});
                mul_b = $signed({17'd0, ts_reg});
            end
            S_A2, S_A5:
            begin
                mul_a = hi_reg;
                mul_b = $signed({17'd0, ts_reg});
            end
            S_A4:
            begin
                mul_a = $signed({17'd0, sum_reg[15:0]});
                mul_b = $signed({17'd0, ts_reg});
            end
            S_V1:
            begin
                mul_a = $signed({17'd0, diff_reg[15:0]});
                mul_b = $signed({2'd0, hr_reg});
            end
            S_V2:
            begin
                mul_a = hi_reg;
                mul_b = $signed({2'd0, hr_reg});
            end
            default:
            begin
            end
        endcase
    end

    // high part product plus the floored low part product
    assign prod_plus = $signed(prod_reg[49:0]) + $signed({19'd0, tmp_reg});
    assign np_wide   = $signed({{19{pos_q[31]}}, pos_q, 1'b0})
                     - $signed({{20{prev_q[31]}}, prev_q})
                     + $signed({{2{sum_reg[49]}}, sum_reg});
    assign vel_sat   = sat32($signed({{2{prod_plus[49]}}, prod_plus}));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        ts_next        = ts_reg;
        hr_next        = hr_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        last_next      = last_reg;
        hi_next        = hi_reg;
        tmp_next       = tmp_reg;
        sum_next       = sum_reg;
        np_next        = np_reg;
        diff_next      = diff_reg;

        if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TIME_STEP: ts_next = cfg.data[15:0];
                CFG_HALF_RATE: hr_next = cfg.data[30:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    axis_next = 2'd0;
                    last_next = 1'b1;
                    case (cmd.mode)
                        MODE_ADD:
                        begin
                            id_next = 5'(count_reg);
                            if (full)
                            begin
                                status_next    = ST_FULL;
                                id_next        = 5'd0;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_ADDED;
                                state_next  = S_AWR;
                            end
                        end
                        MODE_FORCE:
                        begin
                            id_next  = cmd.body_index;
                            idx_next = IW'(cmd.body_index);
                            if (idx_ok)
                            begin
                                status_next = ST_FORCE;
                                state_next  = S_FWR;
                            end
                            else
                            begin
                                status_next    = ST_BAD_IDX;
                                out_valid_next = 1'b1;
                            end
                        end
                        MODE_TICK:
                        begin
                            idx_next = '0;
                            id_next  = 5'd0;
                            if (count_reg == '0)
                            begin
                                status_next    = ST_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_AWR:
            begin
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_ADIV;
                end
            end
            S_ADIV:
            begin
                if (recip_stat.done)
                begin
                    count_next     = count_reg + CW'(1);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FWR:
            begin
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD:
            begin
                // hold the next body until the previous result is taken
                if (!(axis_reg == 2'd0 && out_valid_reg))
                begin
                    state_next = S_MF;
                end
            end
            S_MF: state_next = S_A1;
            S_A1:
            begin
                hi_next    = $signed({prod_reg[63], prod_reg[63:32]});
                state_next = S_A2;
            end
            S_A2:
            begin
                tmp_next   = prod_reg[46:16];
                state_next = S_A3;
            end
            S_A3:
            begin
                sum_next   = prod_plus;
                state_next = S_A4;
            end
            S_A4:
            begin
                hi_next    = sum_reg[48:16];
                state_next = S_A5;
            end
            S_A5:
            begin
                tmp_next   = prod_reg[46:16];
                state_next = S_A6;
            end
            S_A6:
            begin
                sum_next   = prod_plus;
                state_next = S_NP;
            end
            S_NP:
            begin
                np_next    = sat32(np_wide);
                state_next = S_DF;
            end
            S_DF:
            begin
                diff_next  = $signed({np_reg[31], np_reg[31], np_reg})
                           - $signed({prev_q[31], prev_q[31], prev_q});
                state_next = S_V1;
            end
            S_V1:
            begin
                hi_next    = $signed({{15{diff_reg[33]}}, diff_reg[33:16]});
                state_next = S_V2;
            end
            S_V2:
            begin
                tmp_next   = prod_reg[46:16];
                state_next = S_V3;
            end
            S_V3:
            begin
                if (axis_reg == 2'd2)
                begin
                    axis_next      = 2'd0;
                    status_next    = ST_BODY;
                    id_next        = 5'(idx_reg);
                    out_valid_next = 1'b1;
                    last_next      = (CW'(idx_reg) + CW'(1) == count_reg);
                    idx_next       = idx_reg + IW'(1);
                    state_next     = last_next ? S_IDLE : S_RD;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            ts_reg        <= TIME_STEP_RST;
            hr_reg        <= HALF_RATE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            ts_reg        <= ts_next;
            hr_reg        <= hr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= mul_a * mul_b;
        status_reg <= status_next;
        id_reg     <= id_next;
        last_reg   <= last_next;
        hi_reg     <= hi_next;
        tmp_reg    <= tmp_next;
        sum_reg    <= sum_next;
        np_reg     <= np_next;
        diff_reg   <= diff_next;
        if (cmd_fire)
        begin
            a_reg[0] <= cmd.ax;
            a_reg[1] <= cmd.ay;
            a_reg[2] <= cmd.az;
            mass_reg <= cmd.mass;
            if (cmd.mode == MODE_ADD && !full)
            begin
                po_reg[0] <= cmd.ax;
                po_reg[1] <= cmd.ay;
                po_reg[2] <= cmd.az;
                vo_reg[0] <= cmd.vx;
                vo_reg[1] <= cmd.vy;
                vo_reg[2] <= cmd.vz;
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    po_reg[k] <= '0;
                    vo_reg[k] <= '0;
                end
            end
        end
        else if (state_reg == S_V3)
        begin
            po_reg[axis_reg] <= np_reg;
            vo_reg[axis_reg] <= vel_sat;
        end
    end

    assign cmd.ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.body_id = id_reg;
    assign rsp.px      = po_reg[0];
    assign rsp.py      = po_reg[1];
    assign rsp.pz      = po_reg[2];
    assign rsp.velx    = vo_reg[0];
    assign rsp.vely    = vo_reg[1];
    assign rsp.velz    = vo_reg[2];
    assign rsp.last    = last_reg;

    `VBI_ASSERT(a_ready_needs_free_out, clk, rst_n, cmd.ready |-> !rsp.valid)
    `VBI_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(MAX_BODIES))
    `VBI_ASSERT(a_last_is_top, clk, rst_n, (rsp.valid && rsp.status == ST_BODY && rsp.last) |-> (rsp.body_id == 5'(count_reg - CW'(1))))
    `VBI_ASSERT(a_div_done_in_add, clk, rst_n, recip_stat.done |-> (state_reg == S_ADIV))

endmodule

@@ dv/vbi_checker.sv @@
// integrator checker: watches the channels, predicts every result and compares
`timescale 1ns / 1ps

module vbi_checker
    import vbi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vbi_cmd_if   cmd,
    vbi_rsp_if   rsp,
    vbi_cfg_if   cfg,
    output int   errors,
    output int   pending
);

    localparam int BODY_SLOTS = 32;

    typedef struct packed {
        status_t         status;
        logic [4:0]      id;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic            last;
    } body_result_t;

    body_result_t expected_q[$];

    longint      pos_tab[BODY_SLOTS][3];
    longint      prev_tab[BODY_SLOTS][3];
    longint      force_tab[BODY_SLOTS][3];
    logic [31:0] inv_mass[BODY_SLOTS];
    int          body_total;
    logic [15:0] step_len;
    logic [30:0] rate_half;

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic body_result_t plain_result(input status_t st, input logic [4:0] id);
        body_result_t r;
        r = '0;
        r.status = st;
        r.id = id;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_request();
        longint       a[3];
        longint       v[3];
        longint       acc, disp, np, nv, dt, hr;
        logic [63:0]  quot;
        body_result_t r;
        int           id;
        a[0] = longint'(cmd.ax);
        a[1] = longint'(cmd.ay);
        a[2] = longint'(cmd.az);
        v[0] = longint'(cmd.vx);
        v[1] = longint'(cmd.vy);
        v[2] = longint'(cmd.vz);
        case (cmd.mode)
            MODE_ADD:
            begin
                if (body_total >= BODY_SLOTS)
                begin
                    expected_q.push_back(plain_result(ST_FULL, 5'd0));
                end
                else
                begin
                    id = body_total;
                    body_total++;
                    r = plain_result(ST_ADDED, 5'(id));
                    for (int j = 0; j < 3; j++)
                    begin
                        pos_tab[id][j] = a[j];
                        prev_tab[id][j] = a[j];
                        force_tab[id][j] = 0;
                        r.pos[j] = a[j][31:0];
                        r.vel[j] = v[j][31:0];
                    end
                    if (cmd.mass == 0)
                        inv_mass[id] = '0;
                    else
                    begin
                        quot = 64'h1_0000_0000 / {32'd0, cmd.mass};
                        inv_mass[id] = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
                    end
                    expected_q.push_back(r);
                end
            end
            MODE_FORCE:
            begin
                if (int'(cmd.body_index) >= body_total)
                    expected_q.push_back(plain_result(ST_BAD_IDX, cmd.body_index));
                else
                begin
                    for (int j = 0; j < 3; j++)
                        force_tab[cmd.body_index][j] = a[j];
                    expected_q.push_back(plain_result(ST_FORCE, cmd.body_index));
                end
            end
            MODE_TICK:
            begin
                if (body_total == 0)
                    expected_q.push_back(plain_result(ST_EMPTY, 5'd0));
                dt = longint'(step_len);
                hr = longint'(rate_half);
                for (int i = 0; i < body_total; i++)
                begin
                    r = plain_result(ST_BODY, 5'(i));
                    r.last = (i + 1 == body_total);
                    for (int j = 0; j < 3; j++)
                    begin
                        acc = (force_tab[i][j] * longint'(inv_mass[i])) >>> 16;
                        disp = (((acc * dt) >>> 16) * dt) >>> 16;
                        np = clamp32(2 * pos_tab[i][j] - prev_tab[i][j] + disp);
                        // velocity spans the previous position from before this step
                        nv = clamp32(((np - prev_tab[i][j]) * hr) >>> 16);
                        prev_tab[i][j] = pos_tab[i][j];
                        pos_tab[i][j] = np;
                        force_tab[i][j] = 0;
                        r.pos[j] = np[31:0];
                        r.vel[j] = nv[31:0];
                    end
                    expected_q.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic check_result();
        body_result_t e;
        if (expected_q.size() == 0)
        begin
            $error("result with nothing outstanding: status %0d id %0d", rsp.status, rsp.body_id);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        compare_field("status", 32'(e.status), 32'(rsp.status));
        compare_field("body_id", 32'(e.id), 32'(rsp.body_id));
        compare_field("px", e.pos[0], rsp.px);
        compare_field("py", e.pos[1], rsp.py);
        compare_field("pz", e.pos[2], rsp.pz);
        compare_field("velx", e.vel[0], rsp.velx);
        compare_field("vely", e.vel[1], rsp.vely);
        compare_field("velz", e.vel[2], rsp.velz);
        compare_field("last", 32'(e.last), 32'(rsp.last));
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            body_total = 0;
            step_len = TIME_STEP_RST;
            rate_half = HALF_RATE_RST;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_TIME_STEP)
                    step_len = cfg.data[15:0];
                else if (cfg.index == CFG_HALF_RATE)
                    rate_half = cfg.data[30:0];
            end
            if (rsp.valid && rsp.ready)
                check_result();
            if (cmd.valid && cmd.ready)
                predict_request();
        end
        pending = expected_q.size();
    end

endmodule

@@ dv/verlet_body_integrator_test.sv @@
// top of the integrator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module verlet_body_integrator_test;
    import vbi_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS  = 40;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  idx;
        logic [31:0] ax, ay, az, vx, vy, vz, mass;
    } request_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    int   bodies;
    bit   calm;

    vbi_cmd_if cmd_ch ();
    vbi_rsp_if rsp_ch ();
    vbi_cfg_if cfg_ch ();

    verlet_body_integrator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    vbi_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall before each result, none while calm
    initial
    begin
        int  stall;
        bit  took;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = rsp_ch.valid;
                @(posedge clk);
            end while (!took);
        end
    end

    function automatic logic [31:0] field_value();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom();
            4: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            default: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
        endcase
    endfunction

    function automatic logic [31:0] mass_value();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return $urandom();
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(32'h100, 32'h40000);
        endcase
    endfunction

    task automatic issue(input request_t r);
        int gap;
        bit took;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.mode       <= r.mode;
        cmd_ch.body_index <= r.idx;
        cmd_ch.ax         <= r.ax;
        cmd_ch.ay         <= r.ay;
        cmd_ch.az         <= r.az;
        cmd_ch.vx         <= r.vx;
        cmd_ch.vy         <= r.vy;
        cmd_ch.vz         <= r.vz;
        cmd_ch.mass       <= r.mass;
        cmd_ch.valid      <= 1'b1;
        do
        begin
            @(negedge clk);
            took = cmd_ch.ready;
            @(posedge clk);
        end while (!took);
        if (r.mode == MODE_ADD && bodies < 32)
            bodies++;
    endtask

    task automatic request_of(input logic [1:0] mode, input logic [4:0] idx,
                              input logic [31:0] a, input logic [31:0] v,
                              input logic [31:0] mass);
        request_t r;
        r = {mode, idx, a, ~a, a ^ 32'h5555_5555, v, ~v, v ^ 32'hAAAA_AAAA, mass};
        issue(r);
    endtask

    // wait for every outstanding result, then let an ignored request finish
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        // let the checker count the last request before pending is read
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        bit took;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end while (!took);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_request();
        request_t r;
        int       pick;
        r.ax = field_value();
        r.ay = field_value();
        r.az = field_value();
        r.vx = field_value();
        r.vy = field_value();
        r.vz = field_value();
        r.mass = mass_value();
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            r.mode = MODE_ADD;
            r.idx = 5'($urandom());
        end
        else if (pick < 70 && bodies > 0)
        begin
            r.mode = MODE_FORCE;
            r.idx = 5'($urandom_range(0, bodies - 1));
        end
        else if (pick < 90)
        begin
            r.mode = MODE_TICK;
            r.idx = 5'($urandom());
        end
        else if (pick < 95)
        begin
            r.mode = MODE_FORCE;
            r.idx = 5'($urandom());
        end
        else
        begin
            r.mode = 2'd3;
            r.idx = 5'($urandom());
        end
        issue(r);
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        bodies = 0;
        idle_cycles = 0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.mode <= MODE_ADD;
        cmd_ch.body_index <= '0;
        cmd_ch.ax <= '0;
        cmd_ch.ay <= '0;
        cmd_ch.az <= '0;
        cmd_ch.vx <= '0;
        cmd_ch.vy <= '0;
        cmd_ch.vz <= '0;
        cmd_ch.mass <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_TIME_STEP;
        cfg_ch.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table cases, extreme bodies and forces
        request_of(MODE_TICK, 5'd0, 32'd0, 32'd0, 32'd0);
        request_of(MODE_FORCE, 5'd0, 32'd5, 32'd0, 32'd0);
        request_of(2'd3, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        request_of(MODE_ADD, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        request_of(MODE_ADD, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        request_of(MODE_ADD, 5'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        request_of(MODE_ADD, 5'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        request_of(MODE_FORCE, 5'd1, 32'h7FFF_FFFF, 32'd0, 32'd0);
        request_of(MODE_FORCE, 5'd2, 32'h8000_0000, 32'd0, 32'd0);
        request_of(MODE_FORCE, 5'd3, 32'hFFF0_0000, 32'd0, 32'd0);
        request_of(MODE_FORCE, 5'd4, 32'd1, 32'd0, 32'd0);
        request_of(MODE_FORCE, 5'd31, 32'd1, 32'd0, 32'd0);
        request_of(MODE_TICK, 5'd0, 32'd0, 32'd0, 32'd0);
        request_of(MODE_FORCE, 5'd1, 32'h7FFF_FFFF, 32'd0, 32'd0);
        request_of(MODE_FORCE, 5'd0, 32'h8000_0000, 32'd0, 32'd0);
        request_of(MODE_TICK, 5'd0, 32'd0, 32'd0, 32'd0);
        request_of(MODE_TICK, 5'd0, 32'd0, 32'd0, 32'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(CFG_TIME_STEP, 32'(TIME_STEP_RST));
                    write_reg(CFG_HALF_RATE, 32'(HALF_RATE_RST));
                end
                1:
                begin
                    write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
                    write_reg(CFG_HALF_RATE, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(CFG_TIME_STEP, 32'd0);
                    write_reg(CFG_HALF_RATE, 32'd0);
                end
                default:
                begin
                    write_reg(CFG_TIME_STEP, $urandom());
                    write_reg(CFG_HALF_RATE, $urandom());
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                calm = (n < 8);
                random_request();
            end
            calm = 1'b0;
        end

        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
